// ===== rtl/float_exponent_histogram_unit_defines.svh =====
// Assertion macros for the float exponent histogram unit.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef FLOAT_EXPONENT_HISTOGRAM_UNIT_DEFINES_SVH
`define FLOAT_EXPONENT_HISTOGRAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FEH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FEH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fehist_pkg.sv =====
// Types and constants shared by the float exponent histogram unit.
// No dependencies.
package fehist_pkg;

    localparam int unsigned DEF_MAX_BUCKETS = 280;
    localparam int unsigned DEF_COUNT_WIDTH = 64;

    localparam int unsigned BUCKET_W  = 9;
    localparam int unsigned SAMPLE_W  = 32;
    localparam int unsigned COUNT_W   = 64;
    localparam int unsigned PADDR_W   = 3;

    localparam logic [PADDR_W-1:0] REG_FORMAT = 3'd0;

    localparam logic FMT_FP32 = 1'b0;
    localparam logic FMT_FP16 = 1'b1;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [BUCKET_W-1:0] TOTAL_FP32 = 9'd280;
    localparam logic [BUCKET_W-1:0] TOTAL_FP16 = 9'd43;
    localparam logic [BUCKET_W-1:0] MANT_FP32  = 9'd23;
    localparam logic [BUCKET_W-1:0] MANT_FP16  = 9'd10;
    localparam logic [7:0]          EXPMAX_FP32 = 8'hff;
    localparam logic [7:0]          EXPMAX_FP16 = 8'h1f;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_bits;
        logic [BUCKET_W-1:0] bucket_index;
        logic                last_of_batch;
    } item_t;

    typedef struct packed {
        logic [BUCKET_W-1:0] bin_id;
        logic [COUNT_W-1:0]  bucket_count;
        logic                batch_done;
    } result_t;

endpackage

// ===== rtl/float_exponent_histogram_unit.sv =====
// Float exponent histogram unit: classify fp32/fp16 samples into magnitude buckets
// and count them in a counter memory. Depends on fehist_pkg and the defines header.
//
//  channel   handshake                      payload
//  -------   ----------------------------   ----------------------------
//  item      start, busy (accept: start&!busy)  item   (item_t)
//  result    result_valid (one-cycle strobe)     result (result_t)
//  config    APB psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// One beat is accepted per cycle while busy is low; its result passes the input
// register, the counter read and the result register before it strobes.
// Back-to-back hits on the same bucket are forwarded from the write stage.
// After reset the counter memory is cleared one entry a cycle; busy stays high
// until every entry is cleared. Configuration writes are taken during that pass.
// The receiver cannot stall; a result is presented for exactly one cycle.
`include "float_exponent_histogram_unit_defines.svh"

module float_exponent_histogram_unit
    import fehist_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  item_t              item,
    output logic               result_valid,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam logic [BUCKET_W-1:0] MAX_B = BUCKET_W'(MAX_BUCKETS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BUCKETS - 1);

    // Counter memory
    logic [COUNT_WIDTH-1:0] mem [MAX_BUCKETS];

    // Control
    logic          format_reg;
    logic          clear_active_reg;
    logic [AW-1:0] clr_ptr_reg;

    // Input stage
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // Counter stage
    logic                   s2_valid_reg;
    logic                   s2_action_reg;
    logic [BUCKET_W-1:0]    s2_id_reg;
    logic                   s2_last_reg;
    logic                   s2_in_range_reg;
    logic [AW-1:0]          s2_addr_reg;
    logic [COUNT_WIDTH-1:0] mem_rd_reg;
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_val_reg;

    // Result stage
    logic    result_valid_reg;
    result_t result_reg;

    logic                   accept;
    logic                   cfg_write;
    logic [7:0]             s1_expo;
    logic [22:0]            s1_mant;
    logic [7:0]             s1_expmax;
    logic [BUCKET_W-1:0]    s1_total;
    logic [BUCKET_W-1:0]    s1_mbits;
    logic [BUCKET_W-1:0]    s1_id;
    logic [BUCKET_W-1:0]    s1_sel;
    logic                   s1_in_range;
    logic [AW-1:0]          s1_addr;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   wr_en;
    logic                   fwd_hit_next;
    result_t                result_next;

    function automatic logic [BUCKET_W-1:0] bit_len(input logic [22:0] v);
        logic [BUCKET_W-1:0] n;
        n = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (v[i])
                n = BUCKET_W'(i + 1);
        end
        return n;
    endfunction

    assign accept    = start && !clear_active_reg;
    assign cfg_write = psel && penable && pwrite;
    assign busy      = clear_active_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == REG_FORMAT) ? {31'd0, format_reg} : 32'd0;

    // Classify the held sample
    always_comb
    begin
        if (format_reg == FMT_FP16)
        begin
            s1_expo   = {3'd0, s1_item_reg.sample_bits[14:10]};
            s1_mant   = {13'd0, s1_item_reg.sample_bits[9:0]};
            s1_expmax = EXPMAX_FP16;
            s1_total  = TOTAL_FP16;
            s1_mbits  = MANT_FP16;
        end
        else
        begin
            s1_expo   = s1_item_reg.sample_bits[30:23];
            s1_mant   = s1_item_reg.sample_bits[22:0];
            s1_expmax = EXPMAX_FP32;
            s1_total  = TOTAL_FP32;
            s1_mbits  = MANT_FP32;
        end

        if (s1_expo == 8'd0)
            s1_id = bit_len(s1_mant);
        else if (s1_expo == s1_expmax)
            s1_id = (s1_mant == 23'd0) ? s1_total - 9'd2 : s1_total - 9'd1;
        else
            s1_id = {1'b0, s1_expo} + s1_mbits;

        if (s1_item_reg.action == ACT_READ)
        begin
            s1_sel      = s1_item_reg.bucket_index;
            s1_in_range = (s1_sel < s1_total) && (s1_sel < MAX_B);
        end
        else
        begin
            s1_sel      = s1_id;
            s1_in_range = (s1_sel < MAX_B);
        end
        s1_addr = s1_in_range ? s1_sel[AW-1:0] : '0;
    end

    // Counter update with one-deep forwarding from the write stage
    always_comb
    begin
        cur_count    = fwd_hit_reg ? fwd_val_reg : mem_rd_reg;
        count_next   = cur_count + 1'b1;
        wr_en        = s2_valid_reg && (s2_action_reg == ACT_COUNT) && s2_in_range_reg;
        fwd_hit_next = wr_en && s1_in_range && (s2_addr_reg == s1_addr);

        result_next = '0;
        if (s2_action_reg == ACT_COUNT)
        begin
            result_next.bin_id     = s2_id_reg;
            result_next.batch_done = s2_last_reg;
            if (s2_in_range_reg)
                result_next.bucket_count = COUNT_W'(count_next);
        end
        else if (s2_in_range_reg)
        begin
            result_next.bucket_count = COUNT_W'(cur_count);
        end
    end

    // Memory: clearing pass, counter write and registered read
    always_ff @(posedge clk)
    begin
        if (clear_active_reg)
            mem[clr_ptr_reg] <= '0;
        else if (wr_en)
            mem[s2_addr_reg] <= count_next;
        mem_rd_reg <= mem[s1_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg       <= FMT_FP32;
            clear_active_reg <= 1'b1;
            clr_ptr_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr == REG_FORMAT))
                format_reg <= pwdata[0];

            if (clear_active_reg)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == LAST_ADDR)
                    clear_active_reg <= 1'b0;
            end

            s1_valid_reg     <= accept;
            s2_valid_reg     <= s1_valid_reg;
            fwd_hit_reg      <= fwd_hit_next;
            result_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= item;
        s2_action_reg   <= s1_item_reg.action;
        s2_id_reg       <= s1_id;
        s2_last_reg     <= s1_item_reg.last_of_batch;
        s2_in_range_reg <= s1_in_range;
        s2_addr_reg     <= s1_addr;
        fwd_val_reg     <= count_next;
        result_reg      <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `FEH_ASSERT_IMP(a_no_work_in_clear, clear_active_reg, !s1_valid_reg && !s2_valid_reg, "item in flight during clear")
    `FEH_ASSERT_NEXT(a_result_follows, s2_valid_reg, result_valid_reg, "result strobe missing")
    `FEH_ASSERT_IMP(a_result_source, result_valid_reg, $past(s2_valid_reg), "result without work")
    `FEH_ASSERT_IMP(a_clr_ptr_bound, clear_active_reg, clr_ptr_reg <= LAST_ADDR, "clear pointer out of range")

endmodule
